@@ rtl/srt_preemptive_scheduler_top_defines.svh @@
// Assertion macros for the scheduler RTL.
`ifndef SRT_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH
`define SRT_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SRT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SRT_ASSERT(label, prop, msg)
`define SRT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/srt_pkg.sv @@
`timescale 1ns / 1ps

package srt_pkg;

    localparam int ID_W   = 8;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 10;
    localparam int TIME_W = 20;
    localparam int SUM_W  = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        STAT_LOADED = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_RAN    = 3'd2,
        STAT_IDLE   = 3'd3,
        STAT_DONE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SM_IDLE,
        SM_SCAN,
        SM_COMMIT,
        SM_SUM,
        SM_OUT
    } state_t;

    typedef struct packed {
        logic             found;
        logic [BUR_W-1:0] rem;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] burst;
        logic [ID_W-1:0]  id;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic [ID_W-1:0]  id;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] burst;
    } load_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   ran_id;
        logic [TIME_W-1:0] comp;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        logic [SUM_W-1:0]  total;
        logic              all_done;
    } res_t;

endpackage

@@ rtl/srt_cell.sv @@
`timescale 1ns / 1ps

module srt_cell #(
    parameter int MAX_PROCS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [srt_pkg::TIME_W-1:0]        cur_time,
    input  logic [$clog2(MAX_PROCS+1)-1:0]    entry_count,
    input  srt_pkg::load_t                    load,
    input  logic [$clog2(MAX_PROCS)-1:0]      load_slot,
    input  logic                              upd_en,
    input  logic [$clog2(MAX_PROCS)-1:0]      upd_slot,
    input  logic                              tok_valid_in,
    input  srt_pkg::tok_t                     tok_in,
    input  logic [$clog2(MAX_PROCS)-1:0]      slot_in,
    output logic                              tok_valid_out,
    output srt_pkg::tok_t                     tok_out,
    output logic [$clog2(MAX_PROCS)-1:0]      slot_out
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS+1);
    localparam logic [IW-1:0] MY_SLOT = IW'(CELL_IDX);
    localparam logic [CW-1:0] MY_CNT  = CW'(CELL_IDX);

    logic [srt_pkg::ID_W-1:0]  id_reg;
    logic [srt_pkg::ARR_W-1:0] arr_reg;
    logic [srt_pkg::BUR_W-1:0] burst_reg;
    logic [srt_pkg::BUR_W-1:0] rem_reg;
    logic                      fin_reg;
    logic                      tok_valid_reg;
    srt_pkg::tok_t             tok_reg;
    srt_pkg::tok_t             tok_next;
    logic [IW-1:0]             slot_reg;
    logic [IW-1:0]             slot_next;
    logic                      load_hit;
    logic                      upd_hit;
    logic                      eligible;
    logic                      better;

    assign load_hit = load.en && (load_slot == MY_SLOT);
    assign upd_hit  = upd_en && (upd_slot == MY_SLOT);

    always_comb begin
        eligible = (MY_CNT < entry_count) && !fin_reg &&
                   ({{(srt_pkg::TIME_W-srt_pkg::ARR_W){1'b0}}, arr_reg} <= cur_time);
        better   = !tok_in.found || (rem_reg < tok_in.rem) ||
                   ((rem_reg == tok_in.rem) && (arr_reg < tok_in.arr));
        tok_next  = tok_in;
        slot_next = slot_in;
        if (eligible && better) begin
            tok_next.found = 1'b1;
            tok_next.rem   = rem_reg;
            tok_next.arr   = arr_reg;
            tok_next.burst = burst_reg;
            tok_next.id    = id_reg;
            slot_next      = MY_SLOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_in;
            if (load_hit) begin
                fin_reg <= 1'b0;
            end else if (upd_hit && (rem_reg == srt_pkg::BUR_W'(1))) begin
                fin_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_hit) begin
            id_reg    <= load.id;
            arr_reg   <= load.arr;
            burst_reg <= load.burst;
            rem_reg   <= load.burst;
        end else if (upd_hit) begin
            rem_reg <= rem_reg - srt_pkg::BUR_W'(1);
        end
        if (tok_valid_in) begin
            tok_reg  <= tok_next;
            slot_reg <= slot_next;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;
    assign slot_out      = slot_reg;

endmodule

@@ rtl/srt_preemptive_scheduler_top.sv @@
`timescale 1ns / 1ps
`include "srt_preemptive_scheduler_top_defines.svh"

// Preemptive shortest-remaining-time scheduler over a table of MAX_PROCS
// processes held in a row of cells. A load transaction (tuser 0) fills the next
// free cell, or reports the table full; its result passes the output state into
// the output register, and the next transaction can be taken while that result
// is presented. A tick transaction (tuser 1) sends a search token along the row,
// one cell per cycle, then passes the commit state, the sum state when the chosen
// process finishes, and the output state; the length of the cell row sets how
// long a tick holds the scheduler, and no new transaction is taken until the
// tick is through. Ties on remaining time go to the earlier arrival, then to
// the lower slot. Each transaction yields exactly one result, and a new
// transaction is taken while the previous result still waits; a second result
// that cannot be handed over holds the input off until the output register is
// free.

module srt_preemptive_scheduler_top #(
    parameter int MAX_PROCS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // proc_id [7:0], arrival_time [23:8], burst_len [33:24]
    input  logic [39:0] s_tdata,
    // op [0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ran_id [7:0], completion_time [27:8], turnaround [47:28],
    // wait_ticks [67:48], total_wait [91:68], all_done [92]
    output logic [95:0] m_tdata,
    // status [2:0]
    output logic [2:0]  m_tuser
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS+1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS);

    srt_pkg::state_t                state_reg, state_next;
    logic [srt_pkg::TIME_W-1:0]     time_reg, time_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  fin_cnt_reg, fin_cnt_next;
    logic [srt_pkg::SUM_W-1:0]      wait_sum_reg, wait_sum_next;
    srt_pkg::res_t                  res_reg, res_next;
    logic                           m_valid_reg, m_valid_next;
    logic [95:0]                    m_data_reg, m_data_next;
    logic [2:0]                     m_user_reg, m_user_next;

    srt_pkg::load_t                 load;
    logic                           launch;
    logic                           upd_en;
    logic [srt_pkg::BUR_W-1:0]      in_burst;
    logic [srt_pkg::TIME_W-1:0]     burst_ext;
    logic [srt_pkg::TIME_W-1:0]     wt;
    logic [srt_pkg::SUM_W:0]        sum_ext;

    logic                           tok_v    [MAX_PROCS+1];
    srt_pkg::tok_t                  tok      [MAX_PROCS+1];
    logic [IW-1:0]                  slot     [MAX_PROCS+1];

    assign tok_v[0] = launch;
    assign tok[0]   = '0;
    assign slot[0]  = '0;

    assign in_burst = s_tdata[33:24];

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++) begin : g_cell
            srt_cell #(
                .MAX_PROCS (MAX_PROCS),
                .CELL_IDX  (g)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .cur_time      (time_reg),
                .entry_count   (count_reg),
                .load          (load),
                .load_slot     (count_reg[IW-1:0]),
                .upd_en        (upd_en),
                .upd_slot      (slot[MAX_PROCS]),
                .tok_valid_in  (tok_v[g]),
                .tok_in        (tok[g]),
                .slot_in       (slot[g]),
                .tok_valid_out (tok_v[g+1]),
                .tok_out       (tok[g+1]),
                .slot_out      (slot[g+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srt_pkg::SM_IDLE;
            time_reg     <= '0;
            count_reg    <= '0;
            fin_cnt_reg  <= '0;
            wait_sum_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            time_reg     <= time_next;
            count_reg    <= count_next;
            fin_cnt_reg  <= fin_cnt_next;
            wait_sum_reg <= wait_sum_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next    = state_reg;
        time_next     = time_reg;
        count_next    = count_reg;
        fin_cnt_next  = fin_cnt_reg;
        wait_sum_next = wait_sum_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        s_tready      = 1'b0;
        load.en       = 1'b0;
        load.id       = s_tdata[7:0];
        load.arr      = s_tdata[23:8];
        load.burst    = (in_burst == '0) ? srt_pkg::BUR_W'(1) : in_burst;
        launch        = 1'b0;
        upd_en        = 1'b0;
        burst_ext     = srt_pkg::TIME_W'(tok[MAX_PROCS].burst);
        wt            = (res_reg.tat >= burst_ext) ? (res_reg.tat - burst_ext) : '0;
        sum_ext       = {1'b0, wait_sum_reg} + (srt_pkg::SUM_W+1)'(wt);

        case (state_reg)
            srt_pkg::SM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == srt_pkg::OP_LOAD) begin
                        res_next          = '0;
                        res_next.total    = wait_sum_reg;
                        if (count_reg < CNT_MAX) begin
                            load.en           = 1'b1;
                            count_next        = count_reg + CW'(1);
                            res_next.status   = srt_pkg::STAT_LOADED;
                            res_next.all_done = 1'b0;
                        end else begin
                            res_next.status   = srt_pkg::STAT_FULL;
                            res_next.all_done = (fin_cnt_reg == count_reg);
                        end
                        state_next = srt_pkg::SM_OUT;
                    end else begin
                        launch     = 1'b1;
                        state_next = srt_pkg::SM_SCAN;
                    end
                end
            end
            srt_pkg::SM_SCAN: begin
                if (tok_v[MAX_PROCS]) begin
                    state_next = srt_pkg::SM_COMMIT;
                end
            end
            srt_pkg::SM_COMMIT: begin
                if (time_reg != srt_pkg::TIME_MAX) begin
                    time_next = time_reg + srt_pkg::TIME_W'(1);
                end
                res_next          = '0;
                res_next.total    = wait_sum_reg;
                res_next.all_done = (fin_cnt_reg == count_reg);
                state_next        = srt_pkg::SM_OUT;
                if (!tok[MAX_PROCS].found) begin
                    res_next.status = srt_pkg::STAT_IDLE;
                end else begin
                    upd_en          = 1'b1;
                    res_next.ran_id = tok[MAX_PROCS].id;
                    if (tok[MAX_PROCS].rem == srt_pkg::BUR_W'(1)) begin
                        res_next.status = srt_pkg::STAT_DONE;
                        res_next.comp   = (time_reg == srt_pkg::TIME_MAX) ?
                                          srt_pkg::TIME_MAX :
                                          time_reg + srt_pkg::TIME_W'(1);
                        res_next.tat    = res_next.comp -
                                          srt_pkg::TIME_W'(tok[MAX_PROCS].arr);
                        state_next      = srt_pkg::SM_SUM;
                    end else begin
                        res_next.status = srt_pkg::STAT_RAN;
                    end
                end
            end
            srt_pkg::SM_SUM: begin
                fin_cnt_next      = fin_cnt_reg + CW'(1);
                wait_sum_next     = sum_ext[srt_pkg::SUM_W] ? srt_pkg::SUM_MAX :
                                    sum_ext[srt_pkg::SUM_W-1:0];
                res_next.wt       = wt;
                res_next.total    = wait_sum_next;
                res_next.all_done = (fin_cnt_next == count_reg);
                state_next        = srt_pkg::SM_OUT;
            end
            srt_pkg::SM_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_reg.status;
                    m_data_next  = {3'b000, res_reg.all_done, res_reg.total, res_reg.wt,
                                    res_reg.tat, res_reg.comp, res_reg.ran_id};
                    state_next   = srt_pkg::SM_IDLE;
                end
            end
            default: begin
                state_next = srt_pkg::SM_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `SRT_ASSERT(a_fin_le_count, fin_cnt_reg <= count_reg, "More finished entries than loaded ones.")
    `SRT_ASSERT(a_count_max, count_reg <= CNT_MAX, "Entry count beyond table size.")
    `SRT_ASSERT(a_token_in_scan, tok_v[MAX_PROCS] |-> state_reg == srt_pkg::SM_SCAN, "Search token left the row outside a scan.")

endmodule
